// ----- src/ffha_pkg.sv -----
// Shared types and constants of the first-fit heap allocator.
// Used by the controller, the datapath and the top level; depends on nothing.
package ffha_pkg;

    // Field widths fixed by the interface
    localparam int ADDR_W    = 32;
    localparam int OFF_W     = 24;
    localparam int SIZE_W    = 24;
    localparam int END_W     = 26;
    localparam int CFG_IDX_W = 1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_LIMIT = 1'b1;

    // Reset value of the heap limit
    localparam logic [OFF_W-1:0] HEAP_LIMIT_RESET = 24'd65536;

    // Request kinds carried in tuser
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_IGNORED  = 2'd1,
        ST_NO_MEM   = 2'd2,
        ST_BAD_ADDR = 2'd3
    } t_status;

    // One table entry as held in the RAM
    typedef struct packed {
        logic              is_free;
        logic [SIZE_W-1:0] size;
        logic [OFF_W-1:0]  offset;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_REJECT,
        S_HIT,
        S_MISS
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic scan;
        logic reject;
        logic apply_hit;
        logic apply_miss;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic zero_req;
        logic match;
        logic exhausted;
        logic out_free;
    } t_dp_status;

endpackage

// ----- src/ffha_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
module ffha_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/ffha_ctrl.sv -----
// Controller state machine of the first-fit heap allocator.
// Depends on ffha_pkg; drives the datapath through t_dp_cmd.
module ffha_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    input  ffha_pkg::t_dp_status i_status,
    output ffha_pkg::t_dp_cmd   o_cmd
);

    ffha_pkg::t_state r_state;
    ffha_pkg::t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ffha_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ffha_pkg::S_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = ffha_pkg::S_SCAN;
                end
            end
            ffha_pkg::S_SCAN: begin
                if (i_status.zero_req) begin
                    n_state = ffha_pkg::S_REJECT;
                end else if (i_status.match) begin
                    n_state = ffha_pkg::S_HIT;
                end else if (i_status.exhausted) begin
                    n_state = ffha_pkg::S_MISS;
                end
            end
            ffha_pkg::S_REJECT,
            ffha_pkg::S_HIT,
            ffha_pkg::S_MISS: begin
                if (i_status.out_free) begin
                    n_state = ffha_pkg::S_IDLE;
                end
            end
            default: n_state = ffha_pkg::S_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_s_tready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            ffha_pkg::S_IDLE: begin
                o_s_tready = 1'b1;
                o_cmd.load = i_s_tvalid;
            end
            ffha_pkg::S_SCAN:   o_cmd.scan       = 1'b1;
            ffha_pkg::S_REJECT: o_cmd.reject     = i_status.out_free;
            ffha_pkg::S_HIT:    o_cmd.apply_hit  = i_status.out_free;
            ffha_pkg::S_MISS:   o_cmd.apply_miss = i_status.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

// ----- src/ffha_datapath.sv -----
// Datapath of the first-fit heap allocator: config, request, table RAM, scan and result.
// Depends on ffha_pkg and ffha_ram; steered by ffha_ctrl through t_dp_cmd.
module ffha_datapath #(
    parameter int MAX_BLOCKS   = 64,
    parameter int HEADER_BYTES = 24
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [ffha_pkg::CFG_IDX_W-1:0]     i_cfg_addr,
    input  logic [ffha_pkg::ADDR_W-1:0]        i_cfg_wdata,
    input  logic                               i_req_cmd,
    input  logic [ffha_pkg::SIZE_W-1:0]        i_req_size,
    input  logic [ffha_pkg::ADDR_W-1:0]        i_req_addr,
    input  ffha_pkg::t_dp_cmd                  i_cmd,
    output ffha_pkg::t_dp_status               o_status,
    input  logic                               i_out_ready,
    output logic                               o_out_valid,
    output logic [ffha_pkg::ADDR_W-1:0]        o_user_addr,
    output ffha_pkg::t_status                  o_res_status,
    output logic                               o_reused
);

    localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

    // Control state
    logic [ffha_pkg::ADDR_W-1:0] r_heap_base, n_heap_base;
    logic [ffha_pkg::OFF_W-1:0]  r_heap_limit, n_heap_limit;
    logic [CNT_W-1:0]            r_count, n_count;
    logic [ffha_pkg::OFF_W-1:0]  r_break, n_break;
    logic [CNT_W-1:0]            r_rd_idx, n_rd_idx;
    logic                        r_cmp_valid, n_cmp_valid;
    logic                        r_out_valid, n_out_valid;

    // Payload
    logic                        r_cmd;
    logic [ffha_pkg::SIZE_W-1:0] r_req_size;
    logic [ffha_pkg::ADDR_W-1:0] r_req_addr;
    logic [CNT_W-1:0]            r_cmp_idx;
    logic [CNT_W-1:0]            r_hit_idx;
    ffha_pkg::t_entry            r_hit;
    logic [ffha_pkg::ADDR_W-1:0] r_out_addr, n_out_addr;
    ffha_pkg::t_status           r_out_status, n_out_status;
    logic                        r_out_reused, n_out_reused;

    // RAM ports
    logic                          ram_we;
    logic [IDX_W-1:0]              ram_waddr;
    ffha_pkg::t_entry              ram_wentry;
    logic [IDX_W-1:0]              ram_raddr;
    logic [ffha_pkg::ENTRY_W-1:0]  ram_rdata;
    ffha_pkg::t_entry              rd_entry;

    // Scan compare and append arithmetic
    logic [ffha_pkg::ADDR_W-1:0] cmp_user_addr;
    logic                        match;
    logic                        do_issue;
    logic [ffha_pkg::END_W-1:0]  append_end;
    logic                        append_fail;
    logic                        hit_is_last;

    ffha_ram #(
        .WIDTH  (ffha_pkg::ENTRY_W),
        .DEPTH  (MAX_BLOCKS),
        .ADDR_W (IDX_W)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wentry),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_entry      = ffha_pkg::t_entry'(ram_rdata);
    assign cmp_user_addr = r_heap_base + ffha_pkg::ADDR_W'(rd_entry.offset)
                         + ffha_pkg::ADDR_W'(HEADER_BYTES);

    // Compare the entry read in the previous scan cycle
    always_comb begin
        if (r_cmd == ffha_pkg::CMD_ALLOC) begin
            match = r_cmp_valid && rd_entry.is_free && (rd_entry.size >= r_req_size);
        end else begin
            match = r_cmp_valid && (cmp_user_addr == r_req_addr);
        end
    end

    assign do_issue    = i_cmd.scan && (r_rd_idx < r_count);
    assign ram_raddr   = r_rd_idx[IDX_W-1:0];
    assign append_end  = ffha_pkg::END_W'(r_break) + ffha_pkg::END_W'(HEADER_BYTES)
                       + ffha_pkg::END_W'(r_req_size);
    assign append_fail = (append_end > ffha_pkg::END_W'(r_heap_limit))
                       || (r_count >= CNT_W'(MAX_BLOCKS));
    assign hit_is_last = ((r_hit_idx + CNT_W'(1)) == r_count);

    // Status to the controller
    always_comb begin
        o_status.zero_req  = (r_cmd == ffha_pkg::CMD_ALLOC) ? (r_req_size == '0)
                                                             : (r_req_addr == '0);
        o_status.match     = match;
        o_status.exhausted = (r_rd_idx >= r_count) && !r_cmp_valid;
        o_status.out_free  = !r_out_valid || i_out_ready;
    end

    // Next state of the table, the scan and the result
    always_comb begin
        n_heap_base  = r_heap_base;
        n_heap_limit = r_heap_limit;
        n_count      = r_count;
        n_break      = r_break;
        n_rd_idx     = r_rd_idx;
        n_cmp_valid  = 1'b0;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_addr   = r_out_addr;
        n_out_status = r_out_status;
        n_out_reused = r_out_reused;
        ram_we       = 1'b0;
        ram_waddr    = r_hit_idx[IDX_W-1:0];
        ram_wentry   = r_hit;

        // Configuration writes
        if (i_cfg_we) begin
            case (i_cfg_addr)
                ffha_pkg::CFG_HEAP_BASE:  n_heap_base  = i_cfg_wdata;
                ffha_pkg::CFG_HEAP_LIMIT: n_heap_limit = i_cfg_wdata[ffha_pkg::OFF_W-1:0];
                default: ;
            endcase
        end

        // Restart the walk on a new request
        if (i_cmd.load) begin
            n_rd_idx = '0;
        end

        // Issue one table read a cycle
        if (do_issue) begin
            n_rd_idx    = r_rd_idx + CNT_W'(1);
            n_cmp_valid = 1'b1;
        end

        // Finish the request into the output register
        if (i_cmd.reject) begin
            n_out_valid  = 1'b1;
            n_out_addr   = '0;
            n_out_status = ffha_pkg::ST_IGNORED;
            n_out_reused = 1'b0;
        end

        if (i_cmd.apply_hit) begin
            n_out_valid  = 1'b1;
            n_out_status = ffha_pkg::ST_OK;
            if (r_cmd == ffha_pkg::CMD_ALLOC) begin
                // Reuse the free block as it stands
                ram_we             = 1'b1;
                ram_wentry.is_free = 1'b0;
                n_out_addr   = r_heap_base + ffha_pkg::ADDR_W'(r_hit.offset)
                             + ffha_pkg::ADDR_W'(HEADER_BYTES);
                n_out_reused = 1'b1;
            end else begin
                n_out_addr   = '0;
                n_out_reused = 1'b0;
                if (hit_is_last) begin
                    // Drop the last entry and lower the break
                    n_count = r_hit_idx;
                    n_break = r_hit.offset;
                end else begin
                    ram_we             = 1'b1;
                    ram_wentry.is_free = 1'b1;
                end
            end
        end

        if (i_cmd.apply_miss) begin
            n_out_valid  = 1'b1;
            n_out_reused = 1'b0;
            n_out_addr   = '0;
            if (r_cmd == ffha_pkg::CMD_FREE) begin
                n_out_status = ffha_pkg::ST_BAD_ADDR;
            end else if (append_fail) begin
                n_out_status = ffha_pkg::ST_NO_MEM;
            end else begin
                // Append a new block at the break
                n_out_status       = ffha_pkg::ST_OK;
                ram_we             = 1'b1;
                ram_waddr          = r_count[IDX_W-1:0];
                ram_wentry.is_free = 1'b0;
                ram_wentry.size    = r_req_size;
                ram_wentry.offset  = r_break;
                n_count            = r_count + CNT_W'(1);
                n_break            = append_end[ffha_pkg::OFF_W-1:0];
                n_out_addr         = r_heap_base + ffha_pkg::ADDR_W'(r_break)
                                   + ffha_pkg::ADDR_W'(HEADER_BYTES);
            end
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heap_base  <= '0;
            r_heap_limit <= ffha_pkg::HEAP_LIMIT_RESET;
            r_count      <= '0;
            r_break      <= '0;
            r_rd_idx     <= '0;
            r_cmp_valid  <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_heap_base  <= n_heap_base;
            r_heap_limit <= n_heap_limit;
            r_count      <= n_count;
            r_break      <= n_break;
            r_rd_idx     <= n_rd_idx;
            r_cmp_valid  <= n_cmp_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd      <= i_req_cmd;
            r_req_size <= i_req_size;
            r_req_addr <= i_req_addr;
        end
        if (do_issue) begin
            r_cmp_idx <= r_rd_idx;
        end
        // Hold the first matching entry
        if (i_cmd.scan && match) begin
            r_hit_idx <= r_cmp_idx;
            r_hit     <= rd_entry;
        end
        r_out_addr   <= n_out_addr;
        r_out_status <= n_out_status;
        r_out_reused <= n_out_reused;
    end

    assign o_out_valid  = r_out_valid;
    assign o_user_addr  = r_out_addr;
    assign o_res_status = r_out_status;
    assign o_reused     = r_out_reused;

endmodule

// ----- src/first_fit_heap_allocator.sv -----
// Top level of the first-fit heap allocator: controller plus datapath.
// Depends on ffha_pkg, ffha_ctrl, ffha_datapath (and ffha_ram below it).
//
//   Channel   Direction  Signals                         Content
//   s         in         i_s_tvalid/o_s_tready/tdata/tuser  allocate or free request
//   m         out        o_m_tvalid/i_m_tready/tdata/tuser  address, status, reused
//   cfg       in         i_cfg_we/i_cfg_addr/i_cfg_wdata    heap_base, heap_limit
//
// From acceptance to the result register a request walks the table RAM one entry a cycle
// through its single registered read port, up to the first match or the last entry.
// A zero size or null address is rejected straight from the scan state.
// The result register frees the input side: the next request is accepted while a
// result still waits; the final update stalls only while that register is full.
// Reset clears the entry count and the break; the table needs no clearing pass.
module first_fit_heap_allocator #(
    parameter int MAX_BLOCKS   = 64,
    parameter int HEADER_BYTES = 24
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [55:0]                    i_s_tdata,   // req_size[23:0], block_addr[55:24]
    input  logic                           i_s_tuser,   // cmd[0]
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [31:0]                    o_m_tdata,   // user_addr[31:0]
    output logic [2:0]                     o_m_tuser,   // status[1:0], reused[2]
    input  logic                           i_cfg_we,
    input  logic [ffha_pkg::CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [31:0]                    i_cfg_wdata
);

    ffha_pkg::t_dp_cmd    dp_cmd;
    ffha_pkg::t_dp_status dp_status;
    ffha_pkg::t_status    res_status;
    logic                 res_reused;

    ffha_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd)
    );

    ffha_datapath #(
        .MAX_BLOCKS   (MAX_BLOCKS),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_req_cmd    (i_s_tuser),
        .i_req_size   (i_s_tdata[23:0]),
        .i_req_addr   (i_s_tdata[55:24]),
        .i_cmd        (dp_cmd),
        .o_status     (dp_status),
        .i_out_ready  (i_m_tready),
        .o_out_valid  (o_m_tvalid),
        .o_user_addr  (o_m_tdata),
        .o_res_status (res_status),
        .o_reused     (res_reused)
    );

    assign o_m_tuser = {res_reused, res_status};

`ifndef SYNTHESIS
    // An accepted transaction moves the controller out of idle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("input accepted twice in a row");

    // At most one finishing command at a time
    a_one_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({dp_cmd.reject, dp_cmd.apply_hit, dp_cmd.apply_miss}))
        else $error("more than one finishing command");

    // A result is written only when the output register is free
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (dp_cmd.reject || dp_cmd.apply_hit || dp_cmd.apply_miss)
            |-> (!o_m_tvalid || i_m_tready))
        else $error("result written over a pending transaction");

    // A finished request always presents a result next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (dp_cmd.reject || dp_cmd.apply_hit || dp_cmd.apply_miss) |=> o_m_tvalid)
        else $error("finished request gave no result");
`endif

endmodule
